@@ hdl/spn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Salt-and-pepper noise injector package
// Generator constants, command and status types, and the tempering function
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package spn_pkg;

    localparam int PIXEL_BITS_DEF = 8;

    localparam int MT_N  = 312;
    localparam int MT_M  = 156;
    localparam int POS_W = 9;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MT_N - 1);
    localparam logic [POS_W-1:0] POS_HALF = POS_W'(MT_M);

    localparam logic [63:0] MT_MATRIX   = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] MT_UPPER    = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] MT_LOWER    = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] MT_INIT_MUL = 64'd6364136223846793005;
    localparam logic [63:0] NOISE_SEED_RST = 64'd5489;

    localparam logic [63:0] TEMPER_B = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TEMPER_C = 64'h71D6_7FFF_EBEE_0000;
    localparam logic [63:0] TEMPER_D = 64'hFFF7_EEE0_0000_0000;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEPPER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SALT   = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SALT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_HL = 2'd1;
    localparam logic [1:0] MUL_LH = 2'd2;

    localparam logic [1:0] RD_CUR  = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_MID  = 2'd2;

    typedef struct packed {
        logic       load_item;
        logic       seed_first;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       seed_write;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_cur;
        logic       cap_next;
        logic       twist_write;
        logic       temper_en;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic seed_last;
    } sts_t;

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] x;
        x = w;
        x = x ^ ((x >> 29) & TEMPER_B);
        x = x ^ ((x << 17) & TEMPER_C);
        x = x ^ ((x << 37) & TEMPER_D);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage
`default_nettype wire

@@ hdl/spn_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Salt-and-pepper noise injector controller
// Sequences the reseed, the incremental twist of one generator word, the
// tempering and the threshold decision, and owns the result handshake.
// ----------------------------------------------------------------------------
module spn_ctrl
    import spn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pixel_valid,
    output logic      pixel_ready,
    input  wire logic first_of_image,
    output logic      result_valid,
    input  wire logic result_ready,
    output cmd_t      cmd,
    input  wire sts_t sts
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEED0  = 4'd1;
    localparam logic [3:0] ST_MUL0   = 4'd2;
    localparam logic [3:0] ST_MUL1   = 4'd3;
    localparam logic [3:0] ST_MUL2   = 4'd4;
    localparam logic [3:0] ST_SWR    = 4'd5;
    localparam logic [3:0] ST_RD0    = 4'd6;
    localparam logic [3:0] ST_RD1    = 4'd7;
    localparam logic [3:0] ST_RD2    = 4'd8;
    localparam logic [3:0] ST_TWIST  = 4'd9;
    localparam logic [3:0] ST_TEMPER = 4'd10;
    localparam logic [3:0] ST_DECIDE = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign pixel_ready  = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = first_of_image ? ST_SEED0 : ST_RD0;
                end
            end
            ST_SEED0:
            begin
                cmd.seed_first = 1'b1;
                state_next     = ST_MUL0;
            end
            ST_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LL;
                state_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HL;
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LH;
                state_next  = ST_SWR;
            end
            ST_SWR:
            begin
                cmd.seed_write = 1'b1;
                state_next     = sts.seed_last ? ST_RD0 : ST_MUL0;
            end
            ST_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.cap_cur = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_NEXT;
                state_next  = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.cap_next = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_MID;
                state_next   = ST_TWIST;
            end
            ST_TWIST:
            begin
                cmd.twist_write = 1'b1;
                state_next      = ST_TEMPER;
            end
            ST_TEMPER:
            begin
                cmd.temper_en = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/spn_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Salt-and-pepper noise injector datapath
// Configuration registers, generator state memory, seeding multiplier,
// twist and tempering logic, and the result registers.
// ----------------------------------------------------------------------------
module spn_datapath
    import spn_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]           cfg_data,
    input  wire logic [PIXEL_BITS-1:0] pixel_in,
    output logic      [PIXEL_BITS-1:0] pixel_out,
    output logic      [KIND_W-1:0]     noise_kind,
    input  wire cmd_t                  cmd,
    output sts_t                       sts
);

    logic [63:0] pepper_threshold_reg;
    logic [63:0] salt_upper_threshold_reg;
    logic [63:0] noise_seed_reg;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] k_reg;
    logic [POS_W-1:0] k_next;

    logic [63:0] gen_mem [MT_N];

    logic [PIXEL_BITS-1:0] pixel_reg;
    logic [63:0]           x_reg;
    logic [63:0]           prod_reg;
    logic [31:0]           hi_reg;
    logic [63:0]           rd_data_reg;
    logic [63:0]           cur_reg;
    logic [63:0]           next_reg;
    logic [63:0]           v_reg;
    logic [63:0]           tempered_reg;
    logic [PIXEL_BITS-1:0] pixel_out_reg;
    logic [KIND_W-1:0]     kind_reg;

    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      mul_p;
    logic [63:0]      seed_word;
    logic [63:0]      y_word;
    logic [63:0]      twist_word;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] rd_addr;
    logic [POS_W-1:0] wr_addr;
    logic [63:0]      wr_data;
    logic             wr_en;

    assign sts.seed_last = (k_reg == POS_LAST);
    assign pixel_out     = pixel_out_reg;
    assign noise_kind    = kind_reg;

    assign mul_a = (cmd.mul_sel == MUL_HL) ? MT_INIT_MUL[63:32] : MT_INIT_MUL[31:0];
    assign mul_b = (cmd.mul_sel == MUL_LH) ? x_reg[63:32] : x_reg[31:0];
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    assign seed_word  = prod_reg + {hi_reg, 32'd0} + {{(64 - POS_W){1'b0}}, k_reg};
    assign y_word     = (cur_reg & MT_UPPER) | (next_reg & MT_LOWER);
    assign twist_word = rd_data_reg ^ (y_word >> 1) ^ (y_word[0] ? MT_MATRIX : 64'd0);
    assign pos_inc    = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_CUR:  rd_addr = pos_reg;
            RD_NEXT: rd_addr = pos_inc;
            RD_MID:  rd_addr = (pos_reg >= POS_HALF) ? pos_reg - POS_HALF : pos_reg + POS_HALF;
            default: rd_addr = pos_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = cmd.seed_first || cmd.seed_write || cmd.twist_write;
        wr_addr = pos_reg;
        wr_data = twist_word;
        if (cmd.seed_first)
        begin
            wr_addr = '0;
            wr_data = noise_seed_reg;
        end
        else if (cmd.seed_write)
        begin
            wr_addr = k_reg;
            wr_data = seed_word;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        k_next   = k_reg;
        if (cmd.seed_first)
        begin
            pos_next = '0;
            k_next   = POS_W'(1);
        end
        else if (cmd.seed_write)
        begin
            k_next = k_reg + 1'b1;
        end
        else if (cmd.twist_write)
        begin
            pos_next = pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pepper_threshold_reg     <= '0;
            salt_upper_threshold_reg <= '0;
            noise_seed_reg           <= NOISE_SEED_RST;
            pos_reg                  <= '0;
            k_reg                    <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            k_reg   <= k_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PEPPER: pepper_threshold_reg     <= cfg_data;
                    CFG_SALT:   salt_upper_threshold_reg <= cfg_data;
                    CFG_SEED:   noise_seed_reg           <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gen_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= gen_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            pixel_reg <= pixel_in;
        end
        if (cmd.seed_first)
        begin
            x_reg <= noise_seed_reg ^ (noise_seed_reg >> 62);
        end
        else if (cmd.seed_write)
        begin
            x_reg <= seed_word ^ (seed_word >> 62);
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_LL:  prod_reg <= mul_p;
                MUL_HL:  hi_reg   <= mul_p[31:0];
                MUL_LH:  hi_reg   <= hi_reg + mul_p[31:0];
                default: ;
            endcase
        end
        if (cmd.cap_cur)
        begin
            cur_reg <= rd_data_reg;
        end
        if (cmd.cap_next)
        begin
            next_reg <= rd_data_reg;
        end
        if (cmd.twist_write)
        begin
            v_reg <= twist_word;
        end
        if (cmd.temper_en)
        begin
            tempered_reg <= temper(v_reg);
        end
        if (cmd.out_load)
        begin
            if (tempered_reg < pepper_threshold_reg)
            begin
                pixel_out_reg <= '0;
                kind_reg      <= KIND_PEPPER;
            end
            else if (tempered_reg < salt_upper_threshold_reg)
            begin
                pixel_out_reg <= {PIXEL_BITS{1'b1}};
                kind_reg      <= KIND_SALT;
            end
            else
            begin
                pixel_out_reg <= pixel_reg;
                kind_reg      <= KIND_NONE;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/salt_pepper_noise_injector_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Salt-and-pepper noise injector
// Replaces pixel samples with black or full scale according to a 64-bit
// Mersenne-Twister-style draw per sample compared against two configured thresholds.
// ----------------------------------------------------------------------------
// Usage:
// Pixel items enter on pixel_valid/pixel_ready with pixel_in and the
// first_of_image flag; each item yields exactly one result on
// result_valid/result_ready carrying pixel_out and noise_kind.
// Configuration writes on cfg_valid/cfg_ready are always taken and must only
// be issued while no item is in flight.
// An item without the flag passes the read, twist, temper and decide states
// before the next item is accepted; the decide state loads its result into
// the output register. The generator state lives in a single-port-read
// memory, and the twist of one word reads three entries in turn, one per read state.
// An item with first_of_image set first reseeds the 312-word state, word 0 from
// the seed and each later word through a shared 32x32 multiplier in three steps.
// Reset clears the control state and loads the register defaults; the
// first item after reset must carry first_of_image.
// A new item is accepted while a finished result still waits; if the
// receiver stalls, the next result is held until the output register frees.
// ----------------------------------------------------------------------------
module salt_pepper_noise_injector_core
    import spn_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [63:0]           cfg_data,
    input  wire logic                  pixel_valid,
    output logic                       pixel_ready,
    input  wire logic [PIXEL_BITS-1:0] pixel_in,
    input  wire logic                  first_of_image,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic      [PIXEL_BITS-1:0] pixel_out,
    output logic      [KIND_W-1:0]     noise_kind
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    spn_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .first_of_image (first_of_image),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .cmd            (cmd),
        .sts            (sts)
    );

    spn_datapath #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pixel_in),
        .pixel_out  (pixel_out),
        .noise_kind (noise_kind),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule
`default_nettype wire

@@ hdl/spn_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Salt-and-pepper noise injector checker
// Port-level assertions on the result coding and item handshakes, bound to
// the top level.
// ----------------------------------------------------------------------------
module spn_checker
    import spn_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  pixel_valid,
    input wire logic                  pixel_ready,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic [PIXEL_BITS-1:0] pixel_out,
    input wire logic [KIND_W-1:0]     noise_kind
);

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(pixel_out) && $stable(noise_kind))
        else $error("Stalled result changed.");

    a_pepper_black: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (noise_kind == KIND_PEPPER) |-> (pixel_out == '0))
        else $error("Pepper result is not black.");

    a_salt_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (noise_kind == KIND_SALT) |-> (pixel_out == {PIXEL_BITS{1'b1}}))
        else $error("Salt result is not full scale.");

    // Only one item is in flight, so acceptance closes the input for a while.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("Input accepted on consecutive cycles.");

endmodule

bind salt_pepper_noise_injector_core spn_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_spn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pixel_out    (pixel_out),
    .noise_kind   (noise_kind)
);
`default_nettype wire
